>>> hw/rtl/kfsp_pkg.sv
// ----------------------------------------------------------------------------
// kfsp_pkg
// Types and constants shared by the keyed FIFO cells, chain and top level.
// ----------------------------------------------------------------------------
package kfsp_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_BITS_DEF  = 16;
    localparam int DATA_BITS_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_DROP   = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_PURGE  = 3'd3,
        ACT_SEARCH = 3'd4,
        ACT_TAIL   = 3'd5,
        ACT_CLEAR  = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_ROTATE = 1'b1
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/kfsp_cell.sv
// ----------------------------------------------------------------------------
// kfsp_cell
// One entry of the queue: loads a new word, takes its neighbour's or holds.
// ----------------------------------------------------------------------------
module kfsp_cell #(
    parameter int KEY_BITS  = kfsp_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = kfsp_pkg::DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  kfsp_pkg::t_cell_ctrl i_ctrl,
    input  logic [KEY_BITS-1:0]  i_load_key,
    input  logic [DATA_BITS-1:0] i_load_data,
    input  logic [KEY_BITS-1:0]  i_next_key,
    input  logic [DATA_BITS-1:0] i_next_data,
    output logic [KEY_BITS-1:0]  o_key,
    output logic [DATA_BITS-1:0] o_data
);

    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key  <= i_load_key;
            r_data <= i_load_data;
        end else if (i_ctrl.shift) begin
            r_key  <= i_next_key;
            r_data <= i_next_data;
        end
    end

    assign o_key  = r_key;
    assign o_data = r_data;

endmodule

>>> hw/rtl/kfsp_chain.sv
// ----------------------------------------------------------------------------
// kfsp_chain
// Row of entry cells; index 0 is the front. Decodes the load position and
// moves every cell towards the front on a shift.
// ----------------------------------------------------------------------------
module kfsp_chain #(
    parameter int DEPTH     = kfsp_pkg::DEPTH_DEF,
    parameter int KEY_BITS  = kfsp_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = kfsp_pkg::DATA_BITS_DEF,
    parameter int IDX_W     = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic                 i_load,
    input  logic [IDX_W-1:0]     i_load_idx,
    input  logic [KEY_BITS-1:0]  i_load_key,
    input  logic [DATA_BITS-1:0] i_load_data,
    output logic [KEY_BITS-1:0]  o_head_key,
    output logic [DATA_BITS-1:0] o_head_data
);

    logic [KEY_BITS-1:0]  w_key  [DEPTH];
    logic [DATA_BITS-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        kfsp_pkg::t_cell_ctrl w_ctrl;
        logic [KEY_BITS-1:0]  w_next_key;
        logic [DATA_BITS-1:0] w_next_data;

        assign w_ctrl.shift = i_shift;
        assign w_ctrl.load  = i_load && (i_load_idx == IDX_W'(g));

        if (g == DEPTH - 1) begin : g_last
            assign w_next_key  = w_key[g];
            assign w_next_data = w_data[g];
        end else begin : g_mid
            assign w_next_key  = w_key[g+1];
            assign w_next_data = w_data[g+1];
        end

        kfsp_cell #(
            .KEY_BITS  (KEY_BITS),
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_load_key  (i_load_key),
            .i_load_data (i_load_data),
            .i_next_key  (w_next_key),
            .i_next_data (w_next_data),
            .o_key       (w_key[g]),
            .o_data      (w_data[g])
        );
    end

    assign o_head_key  = w_key[0];
    assign o_head_data = w_data[0];

endmodule

>>> hw/rtl/keyed_fifo_with_search_and_purge_top.sv
// ----------------------------------------------------------------------------
// keyed_fifo_with_search_and_purge_top
// Bounded FIFO of keyed entries with append, drop, peek, purge, search,
// tail key and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one command word: action,
//   key and payload. Output channel (o_valid / i_ready) returns one result
//   word per command: status, found, key, payload and occupancy.
//   Append, drop, peek, tail key, clear and unknown actions need no
//   rotation: the result is registered at the accept edge.
//   Purge and search rotate the stored entries once, one entry per
//   cycle, through the front cell.
//   Rate is one command per cycle for the short actions while results are
//   drained; purge and search take no new command until the rotation ends.
//   A command is taken only when the result register is empty or being
//   drained in the same cycle; a stalled receiver therefore holds o_ready
//   low once a result is waiting.
//   Reset empties the queue and drops any pending result; entry contents
//   are not cleared.
// ----------------------------------------------------------------------------
module keyed_fifo_with_search_and_purge_top #(
    parameter int DEPTH     = kfsp_pkg::DEPTH_DEF,
    parameter int KEY_BITS  = kfsp_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = kfsp_pkg::DATA_BITS_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [kfsp_pkg::ACTION_W-1:0]   i_action,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [DATA_BITS-1:0]            i_payload,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [kfsp_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_found,
    output logic [KEY_BITS-1:0]             o_key_out,
    output logic [DATA_BITS-1:0]            o_payload_out,
    output logic [CNT_W-1:0]                o_occupancy
);

    localparam int IDX_W = $clog2(DEPTH);

    kfsp_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_len, n_len;
    logic [CNT_W-1:0]     r_steps, n_steps;
    logic                 r_purge, n_purge;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic                 r_hit, n_hit;
    logic [DATA_BITS-1:0] r_hit_data, n_hit_data;
    logic [KEY_BITS-1:0]  r_tail, n_tail;

    logic                 r_out_valid, n_out_valid;
    kfsp_pkg::t_status    r_status, n_status;
    logic                 r_found, n_found;
    logic [KEY_BITS-1:0]  r_key_out, n_key_out;
    logic [DATA_BITS-1:0] r_payload_out, n_payload_out;

    logic                 w_accept;
    logic                 w_shift;
    logic                 w_load;
    logic [IDX_W-1:0]     w_load_idx;
    logic [KEY_BITS-1:0]  w_load_key;
    logic [DATA_BITS-1:0] w_load_data;
    logic [KEY_BITS-1:0]  w_head_key;
    logic [DATA_BITS-1:0] w_head_data;
    logic [CNT_W-1:0]     w_len_m1;
    logic                 w_match;
    logic                 w_keep;
    kfsp_pkg::t_action    w_action;

    assign o_ready  = (r_state == kfsp_pkg::FSM_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_action = kfsp_pkg::t_action'(i_action);
    assign w_len_m1 = r_len - CNT_W'(1);
    assign w_match  = (w_head_key == r_key);
    assign w_keep   = !(r_purge && w_match);

    kfsp_chain #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS),
        .IDX_W     (IDX_W)
    ) u_chain (
        .i_clk       (i_clk),
        .i_shift     (w_shift),
        .i_load      (w_load),
        .i_load_idx  (w_load_idx),
        .i_load_key  (w_load_key),
        .i_load_data (w_load_data),
        .o_head_key  (w_head_key),
        .o_head_data (w_head_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kfsp_pkg::FSM_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len         <= n_len;
        r_steps       <= n_steps;
        r_purge       <= n_purge;
        r_key         <= n_key;
        r_hit         <= n_hit;
        r_hit_data    <= n_hit_data;
        r_tail        <= n_tail;
        r_status      <= n_status;
        r_found       <= n_found;
        r_key_out     <= n_key_out;
        r_payload_out <= n_payload_out;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_len         = r_len;
        n_steps       = r_steps;
        n_purge       = r_purge;
        n_key         = r_key;
        n_hit         = r_hit;
        n_hit_data    = r_hit_data;
        n_tail        = r_tail;
        n_out_valid   = r_out_valid && !i_ready;
        n_status      = r_status;
        n_found       = r_found;
        n_key_out     = r_key_out;
        n_payload_out = r_payload_out;
        w_shift       = 1'b0;
        w_load        = 1'b0;
        w_load_idx    = r_count[IDX_W-1:0];
        w_load_key    = i_key;
        w_load_data   = i_payload;

        unique case (r_state)
            kfsp_pkg::FSM_IDLE: begin
                if (w_accept) begin
                    n_out_valid   = 1'b1;
                    n_status      = kfsp_pkg::ST_OK;
                    n_found       = 1'b0;
                    n_key_out     = '0;
                    n_payload_out = '0;
                    unique case (w_action) inside
                        kfsp_pkg::ACT_APPEND: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = kfsp_pkg::ST_FULL;
                            end else begin
                                w_load  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                n_tail  = i_key;
                            end
                        end
                        kfsp_pkg::ACT_DROP: begin
                            if (r_count == '0) begin
                                n_status = kfsp_pkg::ST_EMPTY;
                            end else begin
                                w_shift = 1'b1;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        kfsp_pkg::ACT_PEEK: begin
                            if (r_count == '0) begin
                                n_status = kfsp_pkg::ST_EMPTY;
                            end else begin
                                n_found       = 1'b1;
                                n_key_out     = w_head_key;
                                n_payload_out = w_head_data;
                            end
                        end
                        kfsp_pkg::ACT_PURGE, kfsp_pkg::ACT_SEARCH: begin
                            if (r_count == '0) begin
                                if (w_action == kfsp_pkg::ACT_SEARCH) begin
                                    n_status = kfsp_pkg::ST_NOT_FOUND;
                                end
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = kfsp_pkg::FSM_ROTATE;
                                n_len       = r_count;
                                n_steps     = r_count;
                                n_purge     = (w_action == kfsp_pkg::ACT_PURGE);
                                n_key       = i_key;
                                n_hit       = 1'b0;
                            end
                        end
                        kfsp_pkg::ACT_TAIL: begin
                            if (r_count != '0) begin
                                n_key_out = r_tail;
                            end
                        end
                        kfsp_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            kfsp_pkg::FSM_ROTATE: begin
                // take the front entry off and re-append it behind the rest if kept
                w_shift     = 1'b1;
                w_load      = w_keep;
                w_load_idx  = w_len_m1[IDX_W-1:0];
                w_load_key  = w_head_key;
                w_load_data = w_head_data;
                n_len       = w_keep ? r_len : w_len_m1;
                n_steps     = r_steps - CNT_W'(1);
                if (w_keep) begin
                    n_tail = w_head_key;
                end
                if (!r_purge && w_match && !r_hit) begin
                    n_hit      = 1'b1;
                    n_hit_data = w_head_data;
                end
                if (r_steps == CNT_W'(1)) begin
                    n_state       = kfsp_pkg::FSM_IDLE;
                    n_count       = n_len;
                    n_out_valid   = 1'b1;
                    n_status      = kfsp_pkg::ST_OK;
                    n_found       = 1'b0;
                    n_key_out     = '0;
                    n_payload_out = '0;
                    if (!r_purge) begin
                        if (r_hit || w_match) begin
                            n_found       = 1'b1;
                            n_key_out     = r_key;
                            n_payload_out = r_hit ? r_hit_data : w_head_data;
                        end else begin
                            n_status = kfsp_pkg::ST_NOT_FOUND;
                        end
                    end
                end
            end
            default: begin
                n_state = kfsp_pkg::FSM_IDLE;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_key_out     = r_key_out;
    assign o_payload_out = r_payload_out;
    assign o_occupancy   = r_count;

endmodule
